// ----- design/peak_hold_time_binner_macros.svh -----
// Assertion macros for the peak hold time binner.
`ifndef PEAK_HOLD_TIME_BINNER_MACROS_SVH
`define PEAK_HOLD_TIME_BINNER_MACROS_SVH

`ifndef SYNTH

`define PHTB_ASSERT_IMP(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("phtb: same-cycle check failed");

`define PHTB_ASSERT_NXT(name, clk, rst, cond, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("phtb: next-cycle check failed");

`else

`define PHTB_ASSERT_IMP(name, clk, rst, cond, prop)

`define PHTB_ASSERT_NXT(name, clk, rst, cond, prop)

`endif

`endif

// ----- design/phtb_pkg.sv -----
package phtb_pkg;

   localparam int NUM_BINS    = 4096;
   localparam int BIN_W       = $clog2(NUM_BINS);
   localparam int CURSOR_W    = BIN_W + 1;
   localparam int LANES       = 32;
   localparam int LANE_W      = $clog2(LANES);
   localparam int FLAG_WORDS  = NUM_BINS / LANES;
   localparam int WORD_W      = $clog2(FLAG_WORDS);

   localparam int TIME_W      = 24;
   localparam int VALUE_W     = 32;

   localparam int BIN_HALF    = 100;
   localparam int BIN_WIDTH   = 200;
   localparam int PRE_SHIFT   = 3;
   localparam int DIVISOR     = BIN_WIDTH >> PRE_SHIFT;
   localparam int SUM_W       = TIME_W + 1;
   localparam int X_W         = SUM_W - PRE_SHIFT;
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_W     = 23;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);
   localparam int PROD_W      = X_W + RECIP_W;
   localparam int Q_W         = PROD_W - RECIP_SHIFT;

   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef struct packed {
      logic                      func;
      logic [TIME_W-1:0]         sample_time;
      logic signed [VALUE_W-1:0] intensity;
   } req_type;

   typedef struct packed {
      logic                      found;
      logic [TIME_W-1:0]         bin_time;
      logic signed [VALUE_W-1:0] peak_value;
   } rsp_type;

   function automatic logic [VALUE_W-1:0] magnitude(input logic [VALUE_W-1:0] v);
      magnitude = v[VALUE_W-1] ? (VALUE_W'(0) - v) : v;
   endfunction

endpackage

// ----- design/phtb_ram.sv -----
module phtb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/peak_hold_time_binner.sv -----
// Peak hold time binner. Requests arrive on start/req_data and are taken when busy is low.
// An add request (func 0) passes through accept with the reciprocal multiply, then bin
// resolve with the memory read, then write back of the occupied flag and held peak. A
// drain request (func 1) on an empty set is answered in its accept step; otherwise it
// scans the occupied flags 32 bins per cycle from the drain point over 1 to 128 flag
// words, up to the first occupied bin or the last word; the scan rate is set by the one
// read port of the flag memory. Each drain request yields exactly one response, presented
// on rsp_data for a single cycle with rsp_strobe high, in the cycle after the request's
// last cycle; the receiver cannot stall it, so it must take it then. After reset the block
// runs a clearing pass over the 128 flag words, holding busy high until it is done.
`include "peak_hold_time_binner_macros.svh"

module peak_hold_time_binner (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  phtb_pkg::req_type req_data,
   output logic              rsp_strobe,
   output phtb_pkg::rsp_type rsp_data
);
   import phtb_pkg::*;

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_DIV      = 3'd2;
   localparam logic [2:0] S_ADD_WR   = 3'd3;
   localparam logic [2:0] S_DRN_CHK  = 3'd4;
   localparam logic [2:0] S_DRN_PEAK = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [WORD_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [X_W-1:0]      x_ff, x_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [BIN_W-1:0]    bin_ff, bin_in;
   logic [BIN_W-1:0]    scan_ff, scan_in;
   logic [BIN_W-1:0]    lowest_ff, lowest_in;
   logic [BIN_W-1:0]    highest_ff, highest_in;
   logic                any_ff, any_in;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                flag_we;
   logic [WORD_W-1:0]   flag_waddr, flag_raddr;
   logic [LANES-1:0]    flag_wdata, flag_rdata;
   logic                peak_we;
   logic [BIN_W-1:0]    peak_waddr, peak_raddr;
   logic [VALUE_W-1:0]  peak_wdata, peak_rdata;

   logic [SUM_W-1:0]    sum_calc;
   logic [X_W-1:0]      x_calc;
   logic [Q_W-1:0]      q0;
   logic [X_W-1:0]      q0_times;
   logic [X_W-1:0]      rem;
   logic [Q_W-1:0]      q;
   logic [BIN_W-1:0]    bin_calc;
   logic [CURSOR_W-1:0] start_pos;
   logic                drain_empty;
   logic [WORD_W-1:0]   scan_word;
   logic                last_word;
   logic [LANES-1:0]    cand;
   logic                hit;
   logic [LANE_W-1:0]   hit_lane;
   logic [BIN_W-1:0]    hit_bin;
   logic [LANES-1:0]    bin_lane_mask;
   logic                occ;
   logic [TIME_W-1:0]   bin_time_calc;

   phtb_ram #(.WIDTH(LANES), .DEPTH(FLAG_WORDS)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_waddr),
      .wr_data (flag_wdata),
      .rd_addr (flag_raddr),
      .rd_data (flag_rdata)
   );

   phtb_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_BINS)) u_peak_ram (
      .clock   (clock),
      .wr_en   (peak_we),
      .wr_addr (peak_waddr),
      .wr_data (peak_wdata),
      .rd_addr (peak_raddr),
      .rd_data (peak_rdata)
   );

   always_comb begin
      sum_calc = {1'b0, req_data.sample_time} + SUM_W'(BIN_HALF);
      x_calc   = sum_calc[SUM_W-1:PRE_SHIFT];
      q0       = prod_ff[PROD_W-1:RECIP_SHIFT];
      q0_times = X_W'({q0, 4'b0000}) + X_W'({q0, 3'b000}) + X_W'(q0);
      rem      = x_ff - q0_times;
      q        = (rem >= X_W'(DIVISOR)) ? q0 + Q_W'(1) : q0;
      bin_calc = (q > Q_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1) : q[BIN_W-1:0];
   end

   always_comb begin
      start_pos   = (cursor_ff > {1'b0, lowest_ff}) ? cursor_ff : {1'b0, lowest_ff};
      drain_empty = !any_ff || (start_pos > {1'b0, highest_ff});
   end

   always_comb begin
      scan_word = scan_ff[BIN_W-1:LANE_W];
      last_word = (scan_word == highest_ff[BIN_W-1:LANE_W]);
      for (int k = 0; k < LANES; k++) begin
         cand[k] = flag_rdata[k] && (LANE_W'(k) >= scan_ff[LANE_W-1:0]) &&
                   (!last_word || (LANE_W'(k) <= highest_ff[LANE_W-1:0]));
      end
      hit      = |cand;
      hit_lane = '0;
      for (int k = LANES - 1; k >= 0; k--) begin
         if (cand[k]) begin
            hit_lane = LANE_W'(k);
         end
      end
      hit_bin = {scan_word, hit_lane};
   end

   always_comb begin
      bin_lane_mask = LANES'(1) << bin_ff[LANE_W-1:0];
      occ           = |(flag_rdata & bin_lane_mask);
      bin_time_calc = TIME_W'({bin_ff, 7'b0}) + TIME_W'({bin_ff, 6'b0}) +
                      TIME_W'({bin_ff, 3'b0});
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      x_in          = x_ff;
      prod_in       = prod_ff;
      val_in        = val_ff;
      bin_in        = bin_ff;
      scan_in       = scan_ff;
      lowest_in     = lowest_ff;
      highest_in    = highest_ff;
      any_in        = any_ff;
      cursor_in     = cursor_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      flag_we    = 1'b0;
      flag_waddr = bin_ff[BIN_W-1:LANE_W];
      flag_wdata = '0;
      flag_raddr = scan_word;
      peak_we    = 1'b0;
      peak_waddr = bin_ff;
      peak_wdata = val_ff;
      peak_raddr = bin_ff;

      unique case (state_ff)
         S_CLEAR: begin
            flag_we     = 1'b1;
            flag_waddr  = clr_addr_ff;
            flag_wdata  = '0;
            clr_addr_in = clr_addr_ff + WORD_W'(1);
            if (clr_addr_ff == WORD_W'(FLAG_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               if (req_data.func == FUNC_ADD) begin
                  x_in     = x_calc;
                  prod_in  = PROD_W'(x_calc) * PROD_W'(RECIP);
                  val_in   = req_data.intensity;
                  state_in = S_DIV;
               end else if (drain_empty) begin
                  rsp_strobe_in = 1'b1;
                  rsp_data_in   = '0;
                  any_in        = 1'b0;
                  lowest_in     = '0;
                  highest_in    = '0;
                  cursor_in     = '0;
               end else begin
                  scan_in    = start_pos[BIN_W-1:0];
                  flag_raddr = start_pos[BIN_W-1:LANE_W];
                  state_in   = S_DRN_CHK;
               end
            end
         end
         S_DIV: begin
            bin_in     = bin_calc;
            flag_raddr = bin_calc[BIN_W-1:LANE_W];
            peak_raddr = bin_calc;
            if (!any_ff) begin
               any_in     = 1'b1;
               lowest_in  = bin_calc;
               highest_in = bin_calc;
            end else begin
               if (bin_calc < lowest_ff) begin
                  lowest_in = bin_calc;
               end
               if (bin_calc > highest_ff) begin
                  highest_in = bin_calc;
               end
            end
            if ({1'b0, bin_calc} < cursor_ff) begin
               cursor_in = {1'b0, bin_calc};
            end
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            flag_we    = 1'b1;
            flag_wdata = flag_rdata | bin_lane_mask;
            peak_we    = !occ || (magnitude(val_ff) > magnitude(peak_rdata));
            state_in   = S_IDLE;
         end
         S_DRN_CHK: begin
            if (hit) begin
               flag_we    = 1'b1;
               flag_waddr = scan_word;
               flag_wdata = flag_rdata & ~(LANES'(1) << hit_lane);
               peak_raddr = hit_bin;
               bin_in     = hit_bin;
               cursor_in  = {1'b0, hit_bin} + CURSOR_W'(1);
               state_in   = S_DRN_PEAK;
            end else if (last_word) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '0;
               any_in        = 1'b0;
               lowest_in     = '0;
               highest_in    = '0;
               cursor_in     = '0;
               state_in      = S_IDLE;
            end else begin
               scan_in    = {scan_word + WORD_W'(1), LANE_W'(0)};
               flag_raddr = scan_word + WORD_W'(1);
            end
         end
         S_DRN_PEAK: begin
            rsp_strobe_in          = 1'b1;
            rsp_data_in.found      = 1'b1;
            rsp_data_in.bin_time   = bin_time_calc;
            rsp_data_in.peak_value = peak_rdata;
            state_in               = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         lowest_ff     <= '0;
         highest_ff    <= '0;
         any_ff        <= 1'b0;
         cursor_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         lowest_ff     <= lowest_in;
         highest_ff    <= highest_in;
         any_ff        <= any_in;
         cursor_ff     <= cursor_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      val_ff      <= val_in;
      bin_ff      <= bin_in;
      scan_ff     <= scan_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `PHTB_ASSERT_IMP(a_rsp_in_idle, clock, reset, rsp_strobe_ff, state_ff == S_IDLE)
   `PHTB_ASSERT_IMP(a_empty, clock, reset, !any_ff, !(|cursor_ff || |lowest_ff || |highest_ff))
   `PHTB_ASSERT_IMP(a_bounds, clock, reset, any_ff, lowest_ff <= highest_ff)
   `PHTB_ASSERT_NXT(a_emit, clock, reset, state_ff == S_DRN_PEAK, rsp_strobe && rsp_data.found)
   `PHTB_ASSERT_NXT(a_add_div, clock, reset,
                    start && !busy && req_data.func == FUNC_ADD, state_ff == S_DIV)

endmodule
